// File: hw/rtl/cube_map_normal_texel_generator_macros.svh
// ---------------------------------------------------------------------------
// Cube map normal texel generator: assertion macros
// Shared concurrent assertion shorthands, clocked on clock, off in reset.
// ---------------------------------------------------------------------------
`ifndef CUBE_MAP_NORMAL_TEXEL_GENERATOR_MACROS_SVH
`define CUBE_MAP_NORMAL_TEXEL_GENERATOR_MACROS_SVH

// same-cycle implication
`define CMNTG_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cube map texel generator: check failed");

// next-cycle implication
`define CMNTG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cube map texel generator: check failed");

`endif

// File: hw/rtl/cmntg_pkg.sv
// ---------------------------------------------------------------------------
// cmntg_pkg
// Types and constants of the normalization cube map texel generator.
// ---------------------------------------------------------------------------
`default_nettype none

package cmntg_pkg;

   localparam int SIZE_W  = 11;  // face_size register
   localparam int COORD_W = 10;  // column / row
   localparam int MAG_W   = 11;  // |component|, face_size <= 2047
   localparam int SQ_W    = 22;  // component squared
   localparam int N_W     = 24;  // squared length, <= 3 * 2047^2
   localparam int DSQ_W   = 16;  // (2k-255)^2
   localparam int RHS_W   = 38;  // 65025 * c^2
   localparam int LHS_W   = 40;  // d^2 * n
   localparam int BYTE_W  = 8;

   localparam logic [SIZE_W-1:0] FaceSizeReset = SIZE_W'(128);
   localparam logic [DSQ_W-1:0]  PackScale     = DSQ_W'(65025);  // 255^2

   typedef enum logic [2:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   typedef struct packed {
      logic [2:0]         face;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } rsp_type;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } comp_type;

   // state of the per-component search for the output byte
   typedef struct packed {
      logic                         blank;
      logic [2:0]                   neg;
      logic [N_W-1:0]               n;
      logic [2:0][RHS_W-1:0]        rhs;
      logic [2:0][BYTE_W-1:0]       k;
   } search_type;

   typedef logic [DSQ_W-1:0] odd_sq_table_type [128];

   // (2i+1)^2 for i = 0..127, the squares of |2k-255|
   function automatic odd_sq_table_type odd_sq_fill();
      odd_sq_table_type t;
      for (int i = 0; i < 128; i++) begin
         t[i] = DSQ_W'((2 * i + 1) * (2 * i + 1));
      end
      return t;
   endfunction

   localparam odd_sq_table_type OddSqTable = odd_sq_fill();

endpackage

`default_nettype wire

// File: hw/rtl/cube_map_normal_texel_generator.sv
// ---------------------------------------------------------------------------
// cube_map_normal_texel_generator
// Normalization cube map texel: (face, column, row) to packed RGB bytes.
// ---------------------------------------------------------------------------
// Fully pipelined: a texel address is taken on every cycle (busy stays low)
// and its RGB word appears on rsp_word with rsp_valid once it has passed
// every stage; the receiver cannot stall. The pipeline is three front
// stages (clamp and face select, squares, length), eight bit-decision
// stages (one per output bit, each one multiply and compare per channel)
// and the output register. face_size is written over the APB port at byte
// address 0; change it only while no texel is in flight. Face codes 6 and 7
// give black.
`default_nettype none
`include "cube_map_normal_texel_generator_macros.svh"

module cube_map_normal_texel_generator #(
   parameter int MAX_FACE_SIZE = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire cmntg_pkg::req_type   req_word,
   output logic                      rsp_valid,
   output cmntg_pkg::rsp_type        rsp_word,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [2:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import cmntg_pkg::*;

   localparam int Latency = 12;

   logic [SIZE_W-1:0] face_size_ff, face_size_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_word_ff, rsp_word_in;
   logic              csr_write;
   logic [8:0]        stage_valid;
   search_type        stage_word [9];

   assign busy       = 1'b0;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[2] ? '0 : 32'(face_size_ff);

   always_comb begin
      face_size_in = face_size_ff;
      if (csr_write && !csr_paddr[2]) begin
         face_size_in = csr_pwdata[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff <= FaceSizeReset;
      end else begin
         face_size_ff <= face_size_in;
      end
   end

   cmntg_front #(
      .MAX_FACE_SIZE(MAX_FACE_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (start && !busy),
      .req_word   (req_word),
      .face_size  (face_size_ff),
      .srch_valid (stage_valid[0]),
      .srch_word  (stage_word[0])
   );

   for (genvar g = 0; g < 8; g++) begin : g_bit
      cmntg_bit_stage #(
         .BIT(7 - g)
      ) u_bit (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_word   (stage_word[g]),
         .out_valid (stage_valid[g+1]),
         .out_word  (stage_word[g+1])
      );
   end

   always_comb begin
      if (stage_word[8].blank) begin
         rsp_word_in = '0;
      end else begin
         rsp_word_in = '{red:   stage_word[8].k[2],
                         green: stage_word[8].k[1],
                         blue:  stage_word[8].k[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_valid[8];
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `CMNTG_ASSERT_IMPL(a_rsp_has_req, rsp_valid, $past(start, Latency))
   `CMNTG_ASSERT_IMPL(a_bad_face_black,
      rsp_valid && ($past(req_word.face, Latency) > FACE_NEG_Z), rsp_word == '0)
   `CMNTG_ASSERT_IMPL(a_pos_x_red_high,
      rsp_valid && ($past(req_word.face, Latency) == FACE_POS_X), rsp_word.red >= 8'd127)
   `CMNTG_ASSERT_NEXT(a_csr_write_lands,
      csr_write && !csr_paddr[2], face_size_ff == $past(csr_pwdata[SIZE_W-1:0]))

endmodule

`default_nettype wire

// File: hw/rtl/cmntg_front.sv
// ---------------------------------------------------------------------------
// cmntg_front
// Three stages: clamp and face mux, squares, length and scaled squares.
// ---------------------------------------------------------------------------
`default_nettype none

module cmntg_front #(
   parameter int MAX_FACE_SIZE = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire cmntg_pkg::req_type             req_word,
   input  wire logic [cmntg_pkg::SIZE_W-1:0]   face_size,
   output logic                                srch_valid,
   output cmntg_pkg::search_type               srch_word
);
   import cmntg_pkg::*;

   localparam logic [SIZE_W+1:0] MaxSize = (SIZE_W+2)'(MAX_FACE_SIZE);

   logic [SIZE_W-1:0]       s;
   logic [SIZE_W-1:0]       lim;
   logic [COORD_W-1:0]      col_c;
   logic [COORD_W-1:0]      row_c;
   logic signed [SIZE_W+1:0] a_s;
   logic signed [SIZE_W+1:0] b_s;
   logic signed [SIZE_W+1:0] a_abs;
   logic signed [SIZE_W+1:0] b_abs;
   comp_type                ca;
   comp_type                cb;
   comp_type                cs;
   comp_type [2:0]          comp_in;
   logic                    blank_in;

   logic                    v1_ff, v2_ff, v3_ff;
   comp_type [2:0]          comp_ff;
   logic                    blank1_ff, blank2_ff;
   logic [2:0][SQ_W-1:0]    sq_ff;
   logic [2:0]              neg2_ff;
   search_type              srch_ff;
   search_type              srch_in;

   always_comb begin
      s = ({2'b00, face_size} > MaxSize) ? MaxSize[SIZE_W-1:0] : face_size;
      lim = (s == '0) ? '0 : s - SIZE_W'(1);
      col_c = ({1'b0, req_word.column} > lim) ? lim[COORD_W-1:0] : req_word.column;
      row_c = ({1'b0, req_word.row} > lim) ? lim[COORD_W-1:0] : req_word.row;
      a_s = $signed({2'b00, col_c, 1'b1}) - $signed({2'b00, s});
      b_s = $signed({2'b00, row_c, 1'b1}) - $signed({2'b00, s});
      a_abs = a_s[SIZE_W+1] ? -a_s : a_s;
      b_abs = b_s[SIZE_W+1] ? -b_s : b_s;
      ca = '{neg: a_s[SIZE_W+1], mag: a_abs[MAG_W-1:0]};
      cb = '{neg: b_s[SIZE_W+1], mag: b_abs[MAG_W-1:0]};
      cs = '{neg: 1'b0, mag: s};
      blank_in = 1'b0;
      comp_in = '0;
      // lane 2 = x, 1 = y, 0 = z
      unique case (req_word.face)
         FACE_POS_X: comp_in = {cs, {~cb.neg, cb.mag}, {~ca.neg, ca.mag}};
         FACE_NEG_X: comp_in = {{1'b1, cs.mag}, {~cb.neg, cb.mag}, ca};
         FACE_POS_Y: comp_in = {ca, cs, cb};
         FACE_NEG_Y: comp_in = {ca, {1'b1, cs.mag}, {~cb.neg, cb.mag}};
         FACE_POS_Z: comp_in = {ca, {~cb.neg, cb.mag}, cs};
         FACE_NEG_Z: comp_in = {{~ca.neg, ca.mag}, {~cb.neg, cb.mag}, {1'b1, cs.mag}};
         default:    blank_in = 1'b1;
      endcase
   end

   always_comb begin
      srch_in.blank = blank2_ff;
      srch_in.neg   = neg2_ff;
      srch_in.n     = N_W'(sq_ff[0]) + N_W'(sq_ff[1]) + N_W'(sq_ff[2]);
      for (int i = 0; i < 3; i++) begin
         srch_in.rhs[i] = RHS_W'(sq_ff[i]) * RHS_W'(PackScale);
      end
      srch_in.k = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      comp_ff   <= comp_in;
      blank1_ff <= blank_in;
      for (int i = 0; i < 3; i++) begin
         sq_ff[i]   <= SQ_W'(comp_ff[i].mag) * SQ_W'(comp_ff[i].mag);
         neg2_ff[i] <= comp_ff[i].neg;
      end
      blank2_ff <= blank1_ff;
      srch_ff   <= srch_in;
   end

   assign srch_valid = v3_ff;
   assign srch_word  = srch_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cmntg_bit_stage.sv
// ---------------------------------------------------------------------------
// cmntg_bit_stage
// Decides one bit of each output byte: largest k with 2k-255 <= 255*c/|v|.
// ---------------------------------------------------------------------------
`default_nettype none

module cmntg_bit_stage #(
   parameter int BIT = 7
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire cmntg_pkg::search_type   in_word,
   output logic                         out_valid,
   output cmntg_pkg::search_type        out_word
);
   import cmntg_pkg::*;

   localparam logic [BYTE_W-1:0] BitMask = BYTE_W'(1) << BIT;

   logic                    valid_ff;
   search_type              word_ff;
   search_type              word_in;
   logic [BYTE_W-1:0]       cand;
   logic [6:0]              idx;
   logic [LHS_W-1:0]        lhs;
   logic                    ok;

   always_comb begin
      word_in = in_word;
      cand = '0;
      idx = '0;
      lhs = '0;
      ok = 1'b0;
      for (int i = 0; i < 3; i++) begin
         cand = in_word.k[i] | BitMask;
         // |2k-255| = 2*idx+1
         idx = cand[7] ? cand[6:0] : ~cand[6:0];
         lhs = LHS_W'(OddSqTable[idx]) * LHS_W'(in_word.n);
         if (cand[7]) begin
            ok = !in_word.neg[i] && (lhs <= LHS_W'(in_word.rhs[i]));
         end else begin
            ok = !in_word.neg[i] || (lhs >= LHS_W'(in_word.rhs[i]));
         end
         word_in.k[i] = ok ? cand : in_word.k[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

// File: tb/cube_map_normal_texel_generator_tb.sv
// ---------------------------------------------------------------------------
// Cube map normal texel generator testbench
// Drives texel addresses under several face sizes and compares every RGB
// word against a behavioral predictor of exact normalization and packing.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module cube_map_normal_texel_generator_tb;
   import cmntg_pkg::*;

   localparam int     MAX_FACE    = 1024;
   localparam int     LATENCY     = 12;
   localparam int     STALL_LIMIT = 2000;
   localparam int     RAND_TEXELS = 1250;
   localparam [2:0]   FACE_SPARE0 = 3'd6;   // unused face codes give black
   localparam [2:0]   FACE_SPARE1 = 3'd7;
   localparam [2:0]   ADDR_FACE_SIZE = 3'd0;
   localparam [2:0]   ADDR_UNMAPPED  = 3'd4;

   class texel_scoreboard;
      rsp_type     expected_q[$];
      logic [10:0] face_size;
      int          mismatches;
      int          checked;

      function new();
         face_size  = FaceSizeReset;
         mismatches = 0;
         checked    = 0;
      endfunction

      // largest k with 255*(c+L)/(2L) >= k, searched like the hardware
      function logic [7:0] pack(longint c, longint n);
         longint lo, hi, k, d, dm, cm, lhs, rhs;
         bit ok;
         cm  = c < 0 ? -c : c;
         rhs = 65025 * cm * cm;
         lo  = 0;
         hi  = 255;
         while (lo < hi) begin
            k   = (lo + hi + 1) / 2;
            d   = 2 * k - 255;
            dm  = d < 0 ? -d : d;
            lhs = dm * dm * n;
            if (d <= 0 && c >= 0) ok = 1;
            else if (d > 0 && c < 0) ok = 0;
            else if (d > 0) ok = lhs <= rhs;
            else ok = lhs >= rhs;
            if (ok) lo = k;
            else hi = k - 1;
         end
         return lo[7:0];
      endfunction

      function void note_texel(req_type t);
         longint s, lim, col, row, a, b, x, y, z, n;
         rsp_type r;
         s   = face_size > MAX_FACE ? MAX_FACE : face_size;
         lim = s == 0 ? 0 : s - 1;
         col = t.column > lim ? lim : t.column;
         row = t.row > lim ? lim : t.row;
         a   = 2 * col + 1 - s;
         b   = 2 * row + 1 - s;
         r   = '0;
         case (t.face)
            FACE_POS_X: begin x = s;  y = -b; z = -a; end
            FACE_NEG_X: begin x = -s; y = -b; z = a;  end
            FACE_POS_Y: begin x = a;  y = s;  z = b;  end
            FACE_NEG_Y: begin x = a;  y = -s; z = -b; end
            FACE_POS_Z: begin x = a;  y = -b; z = s;  end
            FACE_NEG_Z: begin x = -a; y = -b; z = -s; end
            default: begin x = 0; y = 0; z = 0; end
         endcase
         if (t.face <= FACE_NEG_Z) begin
            n = x * x + y * y + z * z;
            r.red   = pack(x, n);
            r.green = pack(y, n);
            r.blue  = pack(z, n);
         end
         expected_q.push_back(r);
      endfunction

      task report(string what);
         $display("%0t: mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      task check_word(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected word %h", got));
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.red !== want.red)
            report($sformatf("red %h, predicted %h", got.red, want.red));
         if (got.green !== want.green)
            report($sformatf("green %h, predicted %h", got.green, want.green));
         if (got.blue !== want.blue)
            report($sformatf("blue %h, predicted %h", got.blue, want.blue));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_word;
   logic        rsp_valid;
   rsp_type     rsp_word;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   texel_scoreboard sb;
   int  stall_cycles;
   int  texels_sent;
   int  sizes_run;
   bit  allow_idle;

   cube_map_normal_texel_generator #(.MAX_FACE_SIZE(MAX_FACE)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // result checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_word(rsp_word);
         if ((start && !busy) || rsp_valid) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles > STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", stall_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task csr_write(logic [2:0] addr, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_FACE_SIZE) sb.face_size = data[10:0];
   endtask

   // word stays on the bus until taken; start is left high for the next one
   task send_texel(req_type t);
      start    <= 1'b1;
      req_word <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_texel(t);
      texels_sent++;
   endtask

   task pause_sender();
      int gap;
      if (allow_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   function req_type texel(logic [2:0] f, logic [9:0] c, logic [9:0] r);
      req_type t;
      t.face   = f;
      t.column = c;
      t.row    = r;
      return t;
   endfunction

   task random_run(int count, int size);
      req_type t;
      int lim;
      lim = size > MAX_FACE ? MAX_FACE - 1 : (size == 0 ? 0 : size - 1);
      for (int i = 0; i < count; i++) begin
         t.face = $urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
         t.column = $urandom_range(0, 3) == 0 ? 10'($urandom)
                                              : 10'($urandom_range(0, lim));
         t.row    = $urandom_range(0, 3) == 0 ? 10'($urandom)
                                              : 10'($urandom_range(0, lim));
         send_texel(t);
         pause_sender();
      end
   endtask

   initial begin
      int sizes [9];
      sb           = new();
      reset        = 1'b1;
      start        = 1'b0;
      req_word     = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      stall_cycles = 0;
      texels_sent  = 0;
      sizes_run    = 0;
      allow_idle   = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset face size: every face, corners, clamping, spare codes
      for (int f = 0; f < 6; f++) begin
         send_texel(texel(3'(f), 10'd0, 10'd0));
         send_texel(texel(3'(f), 10'd1023, 10'd1023));
         send_texel(texel(3'(f), 10'd127, 10'd0));
      end
      send_texel(texel(FACE_POS_X, 10'd64, 10'd63));
      send_texel(texel(FACE_NEG_Z, 10'd200, 10'd5));
      send_texel(texel(FACE_SPARE0, 10'd3, 10'd3));
      send_texel(texel(FACE_SPARE1, 10'd1023, 10'd0));
      pause_sender();
      drain();
      sizes_run++;

      // unmapped address must not disturb face_size
      csr_write(ADDR_UNMAPPED, 32'd7);
      send_texel(texel(FACE_POS_Y, 10'd10, 10'd100));
      drain();

      sizes = '{2, 1024, 2047, 0, 1, 3, 37, 300, 0};
      sizes[8] = $urandom_range(2, 1024);
      for (int p = 0; p < 9; p++) begin
         csr_write(ADDR_FACE_SIZE, 32'(sizes[p]) | 32'($urandom) << 11);
         if (p == 8) allow_idle = 1'b0;
         random_run(RAND_TEXELS / 9, sizes[p]);
         drain();
         sizes_run++;
      end

      $display("covered %0d texels over %0d face sizes, incl. saturation, zero",
               texels_sent, sizes_run);
      $display("checked %0d words, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/cmntg_pkg.sv
hw/rtl/cmntg_front.sv
hw/rtl/cmntg_bit_stage.sv
hw/rtl/cube_map_normal_texel_generator.sv
tb/cube_map_normal_texel_generator_tb.sv
